>>> sv/qrs_pkg.sv
// shared constants and payload types for the qrs pre-processing chain
`timescale 1ns / 1ps

package qrs_pkg;

   localparam int BANDPASSED_BITS = 14;
   localparam int SLOPE_BITS      = 13;
   localparam int ENERGY_BITS     = 24;

   localparam int LP_TAP      = 6;
   localparam int LP_SPAN     = 12;
   localparam int LP_GAIN     = 6;
   localparam int LP_SHIFT    = 5;
   localparam int HP_SPAN     = 32;
   localparam int HP_DELAY    = 15;
   localparam int HP_SHIFT    = 5;
   localparam int SLOPE_DEPTH = 4;
   localparam int SLOPE_SHIFT = 3;

   localparam int IN_QUEUE_DEPTH  = 4;
   localparam int OUT_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic signed [BANDPASSED_BITS-1:0] bandpassed;
      logic signed [SLOPE_BITS-1:0]      slope;
   } shape_type;

   typedef struct packed {
      shape_type               shape;
      logic [ENERGY_BITS-1:0] energy;
   } result_type;

endpackage

>>> sv/qrs_fifo.sv
// small first-in first-out queue used at the input and result sides
`timescale 1ns / 1ps

module qrs_fifo #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue fill count beyond depth");
`endif

endmodule

>>> sv/qrs_filter.sv
// filter pipeline: low-pass, high-pass, derivative, squaring and window sum
`timescale 1ns / 1ps

module qrs_filter #(
   parameter int SAMPLE_BITS   = 12,
   parameter int WINDOW_LENGTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic signed [SAMPLE_BITS-1:0]  in_sample,
   output logic                           out_valid,
   output qrs_pkg::shape_type             out_shape,
   output logic [2*(SAMPLE_BITS+2)-1+$clog2(WINDOW_LENGTH)-1:0] out_sum
);

   localparam int LPY_W  = SAMPLE_BITS + qrs_pkg::LP_GAIN;
   localparam int LPO_W  = LPY_W - qrs_pkg::LP_SHIFT;
   localparam int HSUM_W = LPO_W + $clog2(qrs_pkg::HP_SPAN);
   localparam int HP_W   = LPO_W + 1;
   localparam int DER_W  = HP_W + qrs_pkg::SLOPE_SHIFT;
   localparam int SQ_W   = 2 * HP_W - 1;
   localparam int PTR_W  = $clog2(WINDOW_LENGTH);
   localparam int SUM_W  = SQ_W + PTR_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LENGTH - 1);

   // low-pass stage
   logic signed [SAMPLE_BITS-1:0] xd_ff [qrs_pkg::LP_SPAN];
   logic signed [LPY_W-1:0]       y1_ff, y2_ff;
   logic signed [LPY_W-1:0]       lp_y_in, lp_scaled;
   logic signed [LPO_W-1:0]       s1_lp_ff;
   logic                          s1_valid_ff;

   // high-pass stage
   logic signed [LPO_W-1:0]  dl_ff [qrs_pkg::HP_SPAN];
   logic signed [HSUM_W-1:0] hsum_ff, hsum_in, hsum_scaled;
   logic signed [HP_W-1:0]   hp_in;
   logic signed [HP_W-1:0]   s2_hp_ff;
   logic                     s2_valid_ff;

   // derivative stage
   logic signed [HP_W-1:0]  sh_ff [qrs_pkg::SLOPE_DEPTH];
   logic signed [DER_W-1:0] der_raw, der_scaled;
   logic signed [HP_W-1:0]  s3_hp_ff, s3_d_ff;
   logic                    s3_valid_ff;

   // squaring stage
   logic signed [2*HP_W-1:0] product;
   logic signed [HP_W-1:0]   s4_hp_ff, s4_d_ff;
   logic [SQ_W-1:0]          s4_sq_ff;
   logic                     s4_valid_ff;

   // window stage
   logic [SQ_W-1:0]  window_mem [WINDOW_LENGTH];
   logic [SQ_W-1:0]  rd_ff, oldest;
   logic [PTR_W-1:0] ptr_ff, ptr_step, ptr_ahead;
   logic             filled_ff;
   logic [SUM_W-1:0] wsum_ff, wsum_in;
   qrs_pkg::shape_type s5_shape_ff;
   logic             s5_valid_ff;
   logic             take1, take2, take3, take4, take5;

   assign take1 = advance && in_valid;
   assign take2 = advance && s1_valid_ff;
   assign take3 = advance && s2_valid_ff;
   assign take4 = advance && s3_valid_ff;
   assign take5 = advance && s4_valid_ff;

   // low-pass recursion, exact modulo the register width
   assign lp_y_in = (y1_ff <<< 1) - y2_ff + LPY_W'(in_sample)
                    - (LPY_W'(xd_ff[qrs_pkg::LP_TAP-1]) <<< 1)
                    + LPY_W'(xd_ff[qrs_pkg::LP_SPAN-1]);
   assign lp_scaled = lp_y_in >>> qrs_pkg::LP_SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         y1_ff <= '0;
         y2_ff <= '0;
         for (int k = 0; k < qrs_pkg::LP_SPAN; k++) begin
            xd_ff[k] <= '0;
         end
         s1_valid_ff <= 1'b0;
      end else begin
         if (take1) begin
            y1_ff    <= lp_y_in;
            y2_ff    <= y1_ff;
            xd_ff[0] <= in_sample;
            for (int k = 1; k < qrs_pkg::LP_SPAN; k++) begin
               xd_ff[k] <= xd_ff[k-1];
            end
         end
         if (advance) begin
            s1_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_lp_ff <= lp_scaled[LPO_W-1:0];
      end
   end

   // high-pass: delayed sample minus scaled running sum
   assign hsum_in     = hsum_ff + HSUM_W'(s1_lp_ff) - HSUM_W'(dl_ff[qrs_pkg::HP_SPAN-1]);
   assign hsum_scaled = hsum_in >>> qrs_pkg::HP_SHIFT;
   assign hp_in       = HP_W'(dl_ff[qrs_pkg::HP_DELAY-1])
                        - HP_W'($signed(hsum_scaled[LPO_W-1:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         hsum_ff <= '0;
         for (int k = 0; k < qrs_pkg::HP_SPAN; k++) begin
            dl_ff[k] <= '0;
         end
         s2_valid_ff <= 1'b0;
      end else begin
         if (take2) begin
            hsum_ff  <= hsum_in;
            dl_ff[0] <= s1_lp_ff;
            for (int k = 1; k < qrs_pkg::HP_SPAN; k++) begin
               dl_ff[k] <= dl_ff[k-1];
            end
         end
         if (advance) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_hp_ff <= hp_in;
      end
   end

   // five-point derivative
   assign der_raw = (DER_W'(s2_hp_ff) <<< 1) + DER_W'(sh_ff[0]) - DER_W'(sh_ff[2])
                    - (DER_W'(sh_ff[3]) <<< 1);
   assign der_scaled = der_raw >>> qrs_pkg::SLOPE_SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < qrs_pkg::SLOPE_DEPTH; k++) begin
            sh_ff[k] <= '0;
         end
         s3_valid_ff <= 1'b0;
      end else begin
         if (take3) begin
            sh_ff[0] <= s2_hp_ff;
            for (int k = 1; k < qrs_pkg::SLOPE_DEPTH; k++) begin
               sh_ff[k] <= sh_ff[k-1];
            end
         end
         if (advance) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_hp_ff <= s2_hp_ff;
         s3_d_ff  <= der_scaled[HP_W-1:0];
      end
   end

   // squaring
   assign product = s3_d_ff * s3_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_hp_ff <= s3_hp_ff;
         s4_d_ff  <= s3_d_ff;
         s4_sq_ff <= product[SQ_W-1:0];
      end
   end

   // moving window; next oldest entry is read one item ahead
   assign ptr_step  = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
   assign ptr_ahead = (ptr_step == PTR_LAST) ? '0 : ptr_step + 1'b1;
   assign oldest    = filled_ff ? rd_ff : '0;
   assign wsum_in   = wsum_ff - SUM_W'(oldest) + SUM_W'(s4_sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         filled_ff   <= 1'b0;
         wsum_ff     <= '0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (take5) begin
            ptr_ff  <= ptr_step;
            wsum_ff <= wsum_in;
            if (ptr_step == '0) begin
               filled_ff <= 1'b1;
            end
         end
         if (advance) begin
            s5_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take5) begin
         window_mem[ptr_step] <= s4_sq_ff;
         rd_ff                <= window_mem[ptr_ahead];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_shape_ff.bandpassed <= qrs_pkg::BANDPASSED_BITS'(s4_hp_ff);
         s5_shape_ff.slope      <= qrs_pkg::SLOPE_BITS'(s4_d_ff);
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_shape = s5_shape_ff;
   assign out_sum   = wsum_ff;

`ifndef SYNTHESIS
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_LAST)
      else $error("window pointer out of range");
   a_fill_wrap: assert property (@(posedge clock) disable iff (reset)
      $rose(filled_ff) |-> ptr_ff == '0)
      else $error("window marked full away from wrap");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(wsum_ff) && $stable(ptr_ff) && $stable(y1_ff))
      else $error("filter state moved during stall");
`endif

endmodule

>>> sv/qrs_divider.sv
// division of the window sum by the window length, two stages
`timescale 1ns / 1ps

module qrs_divider #(
   parameter int DIVISOR = 32,
   parameter int SUM_W   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  qrs_pkg::shape_type                  in_shape,
   input  logic [SUM_W-1:0]                    in_sum,
   output logic                                out_valid,
   output qrs_pkg::result_type                 out_result
);

   localparam int SHIFT_W = $clog2(DIVISOR);
   localparam bit POW2    = ((1 << SHIFT_W) == DIVISOR);

   logic                            valid_a_ff, valid_b_ff;
   qrs_pkg::shape_type              shape_a_ff, shape_b_ff;
   logic [qrs_pkg::ENERGY_BITS-1:0] quo_in, quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         shape_a_ff <= in_shape;
         shape_b_ff <= shape_a_ff;
         quo_ff     <= quo_in;
      end
   end

   if (POW2) begin : g_shift
      logic [SUM_W-1:0] sum_ff;
      logic [SUM_W-1:0] sum_scaled;

      always_ff @(posedge clock) begin
         if (advance) begin
            sum_ff <= in_sum;
         end
      end

      assign sum_scaled = sum_ff >> SHIFT_W;
      assign quo_in     = qrs_pkg::ENERGY_BITS'(sum_scaled);
   end else begin : g_recip
      // reciprocal rounded up, exact for every sum of SUM_W bits
      localparam int RECIP_SHIFT = SUM_W + SHIFT_W;
      localparam int RECIP_W     = SUM_W + 1;
      localparam int LO_W        = (RECIP_W + 1) / 2;
      localparam int HI_W        = RECIP_W - LO_W;
      localparam int PROD_W      = SUM_W + RECIP_W;
      localparam longint unsigned RECIP =
         ((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
      localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
      localparam logic [HI_W-1:0] RECIP_HI = RECIP[RECIP_W-1:LO_W];

      logic [SUM_W+LO_W-1:0] lo_ff;
      logic [SUM_W+HI_W-1:0] hi_ff;
      logic [PROD_W-1:0]     product, product_scaled;

      // split product, summed in the second stage
      always_ff @(posedge clock) begin
         if (advance) begin
            lo_ff <= (SUM_W + LO_W)'(in_sum) * (SUM_W + LO_W)'(RECIP_LO);
            hi_ff <= (SUM_W + HI_W)'(in_sum) * (SUM_W + HI_W)'(RECIP_HI);
         end
      end

      assign product        = (PROD_W'(hi_ff) << LO_W) + PROD_W'(lo_ff);
      assign product_scaled = product >> RECIP_SHIFT;
      assign quo_in         = qrs_pkg::ENERGY_BITS'(product_scaled);
   end

   assign out_valid  = valid_b_ff;
   assign out_result = '{shape: shape_b_ff, energy: quo_ff};

endmodule

>>> sv/qrs_preprocessing_filter_chain_top.sv
// top level of the qrs pre-processing filter chain
`timescale 1ns / 1ps

// Takes one signed ECG sample per transfer and returns one result per sample, in order:
// the band-passed value, its five-point slope and the moving-window energy. Throughput is
// one sample per clock while the result queue does not stall the back end; the recursive
// low-pass, the high-pass running sum and the window sum each close their loop
// combinationally around their own state registers, and the window memory has one write
// and one read-ahead port, which sets that figure. A sample passes through the input
// queue, five filter stages, two stages for the division by the window length (a shift
// for a power of two, otherwise a split reciprocal product) and the result queue. A
// four-entry queue on each side lets input and result sides stall independently. All
// filter history is zero after reset; the window memory is not swept, a fill flag masks
// its entries until the pointer first wraps, so samples are taken straight after reset.

module qrs_preprocessing_filter_chain_top #(
   parameter int SAMPLE_BITS   = 12,
   parameter int WINDOW_LENGTH = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        push,
   output logic                                        full,
   input  logic signed [SAMPLE_BITS-1:0]               req_sample,
   output logic                                        empty,
   input  logic                                        pop,
   output logic signed [qrs_pkg::BANDPASSED_BITS-1:0]  rsp_bandpassed,
   output logic signed [qrs_pkg::SLOPE_BITS-1:0]       rsp_slope,
   output logic [qrs_pkg::ENERGY_BITS-1:0]             rsp_energy
);

   localparam int SUM_W = 2 * (SAMPLE_BITS + 2) - 1 + $clog2(WINDOW_LENGTH);
   localparam int RESULT_W = $bits(qrs_pkg::result_type);

   logic [SAMPLE_BITS-1:0] in_word;
   logic                   in_empty, in_pop;
   logic                   advance;
   logic                   filt_valid;
   qrs_pkg::shape_type     filt_shape;
   logic [SUM_W-1:0]       filt_sum;
   logic                   div_valid;
   qrs_pkg::result_type    div_result;
   logic                   out_push, out_full;
   qrs_pkg::result_type    out_word;

   // back end stalls only when a finished result cannot enter the result queue
   assign advance  = !(div_valid && out_full);
   assign in_pop   = advance && !in_empty;
   assign out_push = advance && div_valid;

   qrs_fifo #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (qrs_pkg::IN_QUEUE_DEPTH)
   ) u_in_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .wr_data (req_sample),
      .pop     (in_pop),
      .empty   (in_empty),
      .rd_data (in_word)
   );

   qrs_filter #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .WINDOW_LENGTH (WINDOW_LENGTH)
   ) u_filter (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (!in_empty),
      .in_sample ($signed(in_word)),
      .out_valid (filt_valid),
      .out_shape (filt_shape),
      .out_sum   (filt_sum)
   );

   qrs_divider #(
      .DIVISOR (WINDOW_LENGTH),
      .SUM_W   (SUM_W)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (filt_valid),
      .in_shape   (filt_shape),
      .in_sum     (filt_sum),
      .out_valid  (div_valid),
      .out_result (div_result)
   );

   qrs_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (qrs_pkg::OUT_QUEUE_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .full    (out_full),
      .wr_data (div_result),
      .pop     (pop),
      .empty   (empty),
      .rd_data (out_word)
   );

   assign rsp_bandpassed = out_word.shape.bandpassed;
   assign rsp_slope      = out_word.shape.slope;
   assign rsp_energy     = out_word.energy;

`ifndef SYNTHESIS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into full result queue");
`endif

endmodule
